// ----- rtl/aesd_pkg.sv -----
// Package for the AES-128 inverse cipher: beat types, inverse S-box and
// the round helper functions (inverse ShiftRows/SubBytes, inverse MixColumns).
// No dependencies.
package aesd_pkg;

   localparam int ROUND_COUNT_DEFAULT = 10;
   localparam int BLOCK_W             = 128;
   localparam int HALF_W              = 64;
   localparam int KEY_ROUND_W         = 4;

   localparam logic OP_LOAD_KEY = 1'b0;
   localparam logic OP_DECRYPT  = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [KEY_ROUND_W-1:0] key_round;
      logic [HALF_W-1:0]      data_high;
      logic [HALF_W-1:0]      data_low;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0] plain_high;
      logic [HALF_W-1:0] plain_low;
   } rsp_type;

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // multiply by a 4-bit constant in GF(2^8)
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p   = a;
      for (int k = 0; k < 4; k++) begin
         if (m[k]) begin
            acc = acc ^ p;
         end
         p = xtime(p);
      end
      return acc;
   endfunction

   // byte i of the state sits in bits 127-8i .. 120-8i
   function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
      return s[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic logic [BLOCK_W-1:0] inv_mix_columns(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      logic [7:0] a0, a1, a2, a3;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         o[BLOCK_W-1-8*(4*c)   -: 8] = gf_mul(a0, 4'he) ^ gf_mul(a1, 4'hb) ^
                                       gf_mul(a2, 4'hd) ^ gf_mul(a3, 4'h9);
         o[BLOCK_W-1-8*(4*c+1) -: 8] = gf_mul(a0, 4'h9) ^ gf_mul(a1, 4'he) ^
                                       gf_mul(a2, 4'hb) ^ gf_mul(a3, 4'hd);
         o[BLOCK_W-1-8*(4*c+2) -: 8] = gf_mul(a0, 4'hd) ^ gf_mul(a1, 4'h9) ^
                                       gf_mul(a2, 4'he) ^ gf_mul(a3, 4'hb);
         o[BLOCK_W-1-8*(4*c+3) -: 8] = gf_mul(a0, 4'hb) ^ gf_mul(a1, 4'hd) ^
                                       gf_mul(a2, 4'h9) ^ gf_mul(a3, 4'he);
      end
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] inv_shift_sub(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[BLOCK_W-1-8*(4*c+r) -: 8] = INV_SBOX[get_byte(s, 4*((c-r+4)%4)+r)];
         end
      end
      return o;
   endfunction

endpackage

// ----- rtl/aes128_block_decrypt.sv -----
// AES inverse cipher top level: a chain of round cells plus the output stage.
// Depends on aesd_pkg and aesd_cell.
//
// Usage: load round keys 0..ROUND_COUNT with load beats (op = 0), then send
// ciphertext beats (op = 1). Each round cell keeps its own round key and one
// block, so decrypt beats enter one per cycle while rsp_stall does not hold
// the chain. The path is ROUND_COUNT+1 registers deep: the ROUND_COUNT cells,
// the first of which loads at the edge that takes the beat, and the final
// key-add register. While rsp_valid is high, rsp_stall holds the whole chain.
// A load beat is held off while any block is still in the chain; a load with
// key_round above ROUND_COUNT is dropped. Round keys are undefined until
// loaded.
module aes128_block_decrypt #(
   parameter int ROUND_COUNT = aesd_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aesd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aesd_pkg::rsp_type rsp_data
);
   import aesd_pkg::*;

   logic                advance;
   logic                busy;
   logic                load_go;
   logic [BLOCK_W-1:0]  key_word;
   logic [BLOCK_W-1:0]  key0_ff;
   logic                stage_valid [ROUND_COUNT+1];
   logic [BLOCK_W-1:0]  stage_data  [ROUND_COUNT+1];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_data_ff, rsp_data_in;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      busy = 1'b0;
      for (int k = 1; k <= ROUND_COUNT; k++) begin
         busy = busy | stage_valid[k];
      end
   end

   // hold a key load until the chain has drained
   assign req_stall = (req_data.op == OP_DECRYPT) ? !advance : busy;
   assign load_go   = req_valid && !req_stall && (req_data.op == OP_LOAD_KEY);
   assign key_word  = {req_data.data_high, req_data.data_low};

   assign stage_valid[0] = req_valid && !req_stall && (req_data.op == OP_DECRYPT);
   assign stage_data[0]  = key_word;

   for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_cell
      aesd_cell #(
         .HAS_MIX (k != 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .key_we    (load_go && (req_data.key_round == KEY_ROUND_W'(ROUND_COUNT - k))),
         .key_data  (key_word),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (load_go && (req_data.key_round == '0)) begin
         key0_ff <= key_word;
      end
   end

   assign rsp_valid_in = stage_valid[ROUND_COUNT];
   assign rsp_data_in  = stage_data[ROUND_COUNT] ^ key0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.plain_high = rsp_data_ff[BLOCK_W-1:HALF_W];
   assign rsp_data.plain_low  = rsp_data_ff[HALF_W-1:0];

endmodule

// ----- rtl/aesd_cell.sv -----
// One round cell of the inverse cipher chain: holds its round key and one
// block in flight. Depends on aesd_pkg.
module aesd_cell #(
   parameter bit HAS_MIX = 1'b1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [aesd_pkg::BLOCK_W-1:0] in_data,
   input  logic                        key_we,
   input  logic [aesd_pkg::BLOCK_W-1:0] key_data,
   output logic                        out_valid,
   output logic [aesd_pkg::BLOCK_W-1:0] out_data
);
   import aesd_pkg::*;

   logic [BLOCK_W-1:0] key_ff;
   logic [BLOCK_W-1:0] data_ff, data_in;
   logic               valid_ff;
   logic [BLOCK_W-1:0] keyed;

   always_comb begin
      keyed = in_data ^ key_ff;
      if (HAS_MIX) begin
         keyed = inv_mix_columns(keyed);
      end
      data_in = inv_shift_sub(keyed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
      if (key_we) begin
         key_ff <= key_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
